/* sv/hsvr_pkg.sv */
// hsvr_pkg: shared widths, constants, types and helpers for the smoothed hsv to rgb core
// no dependencies; used by every rtl file of the block
package hsvr_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 12;
    localparam int W_BITS        = SAMPLE_BITS + FRACTION_BITS;
    localparam int RETAIN_BITS   = 16;
    localparam int COLOR_BITS    = 8;

    localparam logic [RETAIN_BITS-1:0] RETAIN_RESET = 16'd58982;
    localparam logic [W_BITS:0]        ONE_W        = {1'b1, {W_BITS{1'b0}}};

    // one smoothed sample set
    typedef struct packed {
        logic [W_BITS-1:0] hue;
        logic [W_BITS-1:0] sat;
        logic [W_BITS-1:0] val;
    } t_hsv;

    // handshake between front end / back end and the queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SMOOTH,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_ST,
        B_P,
        B_Q,
        B_T,
        B_OUT
    } t_back_state;

    // scale a q0.W channel to 8 bits: (x*255) >> W, saturated
    function automatic logic [COLOR_BITS-1:0] to8(input logic [W_BITS-1:0] x);
        logic [W_BITS+8:0] prod;
        logic [8:0]        top;
        begin
            prod = ({1'b0, x, 8'd0}) - {9'd0, x};
            top  = prod[W_BITS+8:W_BITS];
            to8  = (top > 9'd255) ? 8'd255 : top[7:0];
        end
    endfunction

endpackage

/* sv/hsvr_if.sv */
// hsvr_in_if / hsvr_out_if: valid-ready channels for sample sets and colors
// depends on hsvr_pkg for field widths
interface hsvr_in_if;
    logic                               valid;
    logic                               ready;
    logic [hsvr_pkg::SAMPLE_BITS-1:0]   hue_sample;
    logic [hsvr_pkg::SAMPLE_BITS-1:0]   saturation_sample;
    logic [hsvr_pkg::SAMPLE_BITS-1:0]   value_sample;

    modport source (output valid, hue_sample, saturation_sample, value_sample, input ready);
    modport sink   (input valid, hue_sample, saturation_sample, value_sample, output ready);
endinterface

interface hsvr_out_if;
    logic                              valid;
    logic                              ready;
    logic [hsvr_pkg::COLOR_BITS-1:0]   red;
    logic [hsvr_pkg::COLOR_BITS-1:0]   green;
    logic [hsvr_pkg::COLOR_BITS-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

/* sv/smoothed_hsv_to_rgb_core.sv */
// smoothed_hsv_to_rgb_core: top level of the smoothed hsv to rgb converter
// depends on hsvr_pkg, hsvr_if, hsvr_front, hsvr_queue, hsvr_back
//
// Each request carries hue, saturation and value samples; each is run through
// an exponential smoother weighted by the retain factor (q0.16, reset 58982),
// and one rgb color comes out per request. The front end steps through the accept
// step, three smoother steps on one multiplier pair, then a queue push; the back
// end steps through a load, five products on one shared multiplier and an output
// step, so the back end sets the sustained request rate, which drops further while
// the color side holds ready low. Each side takes a new request only when done with its last.
// A two-entry queue and the output register decouple both sides.
module smoothed_hsv_to_rgb_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hsvr_pkg::RETAIN_BITS-1:0] i_cfg_data,
    hsvr_in_if.sink                          i_in,
    hsvr_out_if.source                       o_out
);

    logic [hsvr_pkg::RETAIN_BITS-1:0] r_retain;
    logic             q_push, q_pop;
    hsvr_pkg::t_q_ctl q_ctl;
    hsvr_pkg::t_q_sts q_sts;
    hsvr_pkg::t_hsv   push_data, q_data;

    assign q_ctl = '{push: q_push, pop: q_pop};

    // retain factor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_retain <= hsvr_pkg::RETAIN_RESET;
        else if (i_cfg_we) r_retain <= i_cfg_data;
    end

    hsvr_front u_front (
        .i_clk, .i_rst_n,
        .i_retain    (r_retain),
        .i_in        (i_in),
        .i_q_sts     (q_sts),
        .o_push      (q_push),
        .o_push_data (push_data)
    );

    hsvr_queue u_queue (
        .i_clk, .i_rst_n,
        .i_ctl  (q_ctl),
        .i_data (push_data),
        .o_sts  (q_sts),
        .o_data (q_data)
    );

    hsvr_back u_back (
        .i_clk, .i_rst_n,
        .i_q_sts  (q_sts),
        .i_q_data (q_data),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

endmodule

/* sv/hsvr_front.sv */
// hsvr_front: accepts sample sets and runs the three exponential smoothers
// depends on hsvr_pkg; feeds hsvr_queue
module hsvr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [hsvr_pkg::RETAIN_BITS-1:0]    i_retain,
    hsvr_in_if.sink                             i_in,
    input  hsvr_pkg::t_q_sts                    i_q_sts,
    output logic                                o_push,
    output hsvr_pkg::t_hsv                      o_push_data
);

    hsvr_pkg::t_front_state r_state, n_state;
    logic [1:0]                        r_idx;
    logic [hsvr_pkg::SAMPLE_BITS-1:0]  r_samp [3];
    logic [hsvr_pkg::W_BITS-1:0]       r_sm   [3];

    logic                              accept;
    logic [hsvr_pkg::W_BITS-1:0]       old_v;
    logic [hsvr_pkg::W_BITS-1:0]       x_v;
    logic [hsvr_pkg::RETAIN_BITS:0]    take;
    logic [hsvr_pkg::W_BITS+hsvr_pkg::RETAIN_BITS-1:0] keep_prod;
    logic [hsvr_pkg::W_BITS+hsvr_pkg::RETAIN_BITS:0]   take_prod;
    logic [hsvr_pkg::W_BITS+hsvr_pkg::RETAIN_BITS+1:0] acc;

    assign accept = i_in.valid && i_in.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsvr_pkg::F_IDLE:   if (accept) n_state = hsvr_pkg::F_SMOOTH;
            hsvr_pkg::F_SMOOTH: if (r_idx == 2'd2) n_state = hsvr_pkg::F_PUSH;
            hsvr_pkg::F_PUSH:   if (!i_q_sts.full) n_state = hsvr_pkg::F_IDLE;
            default:            n_state = hsvr_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == hsvr_pkg::F_IDLE);
        o_push     = (r_state == hsvr_pkg::F_PUSH) && !i_q_sts.full;
    end

    assign o_push_data = '{hue: r_sm[0], sat: r_sm[1], val: r_sm[2]};

    // one smoother step: old*keep + (sample<<F)*(65536-keep), >> 16
    always_comb begin
        old_v     = r_sm[r_idx];
        x_v       = {r_samp[r_idx], {hsvr_pkg::FRACTION_BITS{1'b0}}};
        take      = {1'b1, {hsvr_pkg::RETAIN_BITS{1'b0}}} - {1'b0, i_retain};
        keep_prod = old_v * i_retain;
        take_prod = x_v * take;
        acc       = {2'd0, keep_prod} + {1'b0, take_prod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsvr_pkg::F_IDLE;
            r_idx   <= 2'd0;
            r_sm[0] <= '0;
            r_sm[1] <= '0;
            r_sm[2] <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx     <= 2'd0;
                r_samp[0] <= i_in.hue_sample;
                r_samp[1] <= i_in.saturation_sample;
                r_samp[2] <= i_in.value_sample;
            end
            if (r_state == hsvr_pkg::F_SMOOTH) begin
                r_sm[r_idx] <= acc[hsvr_pkg::W_BITS+hsvr_pkg::RETAIN_BITS-1:hsvr_pkg::RETAIN_BITS];
                r_idx       <= r_idx + 2'd1;
            end
        end
    end

endmodule

/* sv/hsvr_queue.sv */
// hsvr_queue: two-entry queue of smoothed sample sets between front and back end
// depends on hsvr_pkg
module hsvr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsvr_pkg::t_q_ctl   i_ctl,
    input  hsvr_pkg::t_hsv     i_data,
    output hsvr_pkg::t_q_sts   o_sts,
    output hsvr_pkg::t_hsv     o_data
);

    hsvr_pkg::t_hsv r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_sts.full  = (r_cnt == 2'd2);
    assign o_sts.empty = (r_cnt == 2'd0);
    assign o_data      = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) r_mem[r_wp] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_ctl.push) r_wp <= ~r_wp;
            if (i_ctl.pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_ctl.push} - {1'b0, i_ctl.pop};
        end
    end

endmodule

/* sv/hsvr_back.sv */
// hsvr_back: hsv to rgb conversion over a shared multiplier, with output register
// depends on hsvr_pkg; pulls from hsvr_queue
module hsvr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsvr_pkg::t_q_sts   i_q_sts,
    input  hsvr_pkg::t_hsv     i_q_data,
    output logic               o_pop,
    hsvr_out_if.source         o_out
);

    localparam int W = hsvr_pkg::W_BITS;

    hsvr_pkg::t_back_state r_state, n_state;
    logic [2:0]     r_sector;
    logic [W-1:0]   r_ff, r_s, r_v, r_sq, r_st, r_p, r_q, r_t;
    logic           r_ovalid;
    logic [7:0]     r_red, r_green, r_blue;

    logic [W:0]     mul_a;
    logic [W-1:0]   mul_b;
    logic [2*W:0]   prod;
    logic [W-1:0]   prod_hi;
    logic [W+2:0]   h6;
    logic           out_free;
    logic [W-1:0]   sel_r, sel_g, sel_b;

    assign out_free = !r_ovalid || o_out.ready;
    assign h6       = {1'b0, i_q_data.hue, 2'b00} + {2'b00, i_q_data.hue, 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsvr_pkg::B_IDLE:  if (!i_q_sts.empty) n_state = hsvr_pkg::B_SQ;
            hsvr_pkg::B_SQ:    n_state = hsvr_pkg::B_ST;
            hsvr_pkg::B_ST:    n_state = hsvr_pkg::B_P;
            hsvr_pkg::B_P:     n_state = hsvr_pkg::B_Q;
            hsvr_pkg::B_Q:     n_state = hsvr_pkg::B_T;
            hsvr_pkg::B_T:     n_state = hsvr_pkg::B_OUT;
            hsvr_pkg::B_OUT:   if (out_free) n_state = hsvr_pkg::B_IDLE;
            default:           n_state = hsvr_pkg::B_IDLE;
        endcase
    end

    // outputs: queue pop and multiplier operands
    always_comb begin
        o_pop = (r_state == hsvr_pkg::B_IDLE) && !i_q_sts.empty;
        mul_a = '0;
        mul_b = r_v;
        unique case (r_state)
            hsvr_pkg::B_SQ: begin mul_a = {1'b0, r_ff}; mul_b = r_s; end
            hsvr_pkg::B_ST: begin mul_a = hsvr_pkg::ONE_W - {1'b0, r_ff}; mul_b = r_s; end
            hsvr_pkg::B_P:  mul_a = hsvr_pkg::ONE_W - {1'b0, r_s};
            hsvr_pkg::B_Q:  mul_a = hsvr_pkg::ONE_W - {1'b0, r_sq};
            hsvr_pkg::B_T:  mul_a = hsvr_pkg::ONE_W - {1'b0, r_st};
            default:        mul_a = '0;
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_hi = prod[2*W-1:W];

    // channel selection by sector; zero saturation makes p, q and t equal v
    always_comb begin
        case (r_sector)
            3'd0:    begin sel_r = r_v; sel_g = r_t; sel_b = r_p; end
            3'd1:    begin sel_r = r_q; sel_g = r_v; sel_b = r_p; end
            3'd2:    begin sel_r = r_p; sel_g = r_v; sel_b = r_t; end
            3'd3:    begin sel_r = r_p; sel_g = r_q; sel_b = r_v; end
            3'd4:    begin sel_r = r_t; sel_g = r_p; sel_b = r_v; end
            default: begin sel_r = r_v; sel_g = r_p; sel_b = r_q; end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sector <= h6[W+2:W];
            r_ff     <= h6[W-1:0];
            r_s      <= i_q_data.sat;
            r_v      <= i_q_data.val;
        end
        if (r_state == hsvr_pkg::B_SQ) r_sq <= prod_hi;
        if (r_state == hsvr_pkg::B_ST) r_st <= prod_hi;
        if (r_state == hsvr_pkg::B_P)  r_p  <= prod_hi;
        if (r_state == hsvr_pkg::B_Q)  r_q  <= prod_hi;
        if (r_state == hsvr_pkg::B_T)  r_t  <= prod_hi;
        if (r_state == hsvr_pkg::B_OUT && out_free) begin
            r_red   <= hsvr_pkg::to8(sel_r);
            r_green <= hsvr_pkg::to8(sel_g);
            r_blue  <= hsvr_pkg::to8(sel_b);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsvr_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hsvr_pkg::B_OUT && out_free) r_ovalid <= 1'b1;
            else if (o_out.ready)                      r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.red   = r_red;
    assign o_out.green = r_green;
    assign o_out.blue  = r_blue;

endmodule

/* sv/hsvr_checker.sv */
// hsvr_checker: port-level assertions for smoothed_hsv_to_rgb_core, bound to the top
// depends on nothing but the top level's ports
module hsvr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue
);

    // no color right after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // front end is busy smoothing after it takes a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while smoothing");

    // a stalled color stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("stalled color changed");

endmodule

bind smoothed_hsv_to_rgb_core hsvr_checker u_hsvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_red       (o_out.red),
    .i_green     (o_out.green),
    .i_blue      (o_out.blue)
);
